// ===== hw/rtl/saa_pkg.sv =====
package saa_pkg;
  localparam int CordicSteps = 16;
  localparam int AccumBits = 48;
  localparam int OutBits = 48;
  localparam int StepBits = $clog2(CordicSteps);
  // phase: 42-bit product sums, times 16 -> up to ~48 bits
  localparam int PhaseBits = 48;
  localparam int CBits = 34;
  localparam logic signed [PhaseBits-1:0] TwoPiQ30 = 48'sd6746518852;
  localparam logic signed [PhaseBits-1:0] PiQ30 = 48'sd3373259426;
  localparam logic signed [PhaseBits-1:0] HalfPiQ30 = 48'sd1686629713;
  localparam logic signed [CBits-1:0] GainQ30 = 34'sd652032874;
  // floor(2^64 / 2pi in Q.30), for the quotient estimate of the reduction
  localparam logic [31:0] RecipTwoPi = 32'((65'd1 << 64) / 65'd6746518852);
  localparam int RedBits = 2;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic red_step;
    logic red_fix;
    logic cordic_init;
    logic cordic_step;
    logic term;
    logic acc;
    logic out_load;
  } saa_cmd_t;

  typedef struct packed {
    logic red_done;
    logic cordic_done;
    logic last;
  } saa_sts_t;

  function automatic logic signed [CBits-1:0] atan_q30(input logic [4:0] i);
    logic signed [CBits-1:0] r;
    unique case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      5'd24: r = 34'sd63;
      5'd25: r = 34'sd31;
      5'd26: r = 34'sd15;
      5'd27: r = 34'sd7;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== hw/rtl/saa_if.sv =====
interface saa_in_if;
  logic valid;
  logic ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic signed [19:0] form_factor;
  logic last_atom;
  modport source(output valid, pos_x, pos_y, pos_z, form_factor, last_atom, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, form_factor, last_atom, output ready);
endinterface

interface saa_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] amp_real;
  logic signed [47:0] amp_imag;
  modport source(output valid, amp_real, amp_imag, input ready);
  modport sink(input valid, amp_real, amp_imag, output ready);
endinterface

// ===== hw/rtl/saa_ctrl.sv =====
module saa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  input  saa_pkg::saa_sts_t sts_i,
  output saa_pkg::saa_cmd_t cmd_o
);
  import saa_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul = 3'd1;
  localparam logic [2:0] StRed = 3'd2;
  localparam logic [2:0] StFix = 3'd3;
  localparam logic [2:0] StCordic = 3'd4;
  localparam logic [2:0] StTerm = 3'd5;
  localparam logic [2:0] StAcc = 3'd6;
  localparam logic [2:0] StOut = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] mcnt_q, mcnt_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    mcnt_d = mcnt_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          mcnt_d = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd2) state_d = StRed;
      end
      StRed: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.red_done) state_d = StFix;
      end
      StFix: begin
        cmd_o.red_fix = 1'b1;
        state_d = StCordic;
      end
      StCordic: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_done) state_d = StTerm;
      end
      StTerm: begin
        cmd_o.term = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        if (!(sts_i.last && out_busy_i)) begin
          cmd_o.acc = 1'b1;
          state_d = sts_i.last ? StOut : StIdle;
        end
      end
      StOut: begin
        cmd_o.out_load = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    cmd_o.cordic_init = cmd_o.red_fix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mcnt_q <= '0;
    end else begin
      state_q <= state_d;
      mcnt_q <= mcnt_d;
    end
  end
endmodule

// ===== hw/rtl/saa_dp.sv =====
module saa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  saa_pkg::saa_cmd_t   cmd_i,
  output saa_pkg::saa_sts_t   sts_o,
  input  logic signed [17:0]  qx_i,
  input  logic signed [17:0]  qy_i,
  input  logic signed [17:0]  qz_i,
  input  logic signed [23:0]  px_i,
  input  logic signed [23:0]  py_i,
  input  logic signed [23:0]  pz_i,
  input  logic signed [19:0]  ff_i,
  input  logic                last_i,
  output logic signed [saa_pkg::AccumBits-1:0] real_o,
  output logic signed [saa_pkg::AccumBits-1:0] imag_neg_o
);
  import saa_pkg::*;

  localparam logic signed [AccumBits-1:0] AccMax = {1'b0, {(AccumBits-1){1'b1}}};
  localparam logic signed [AccumBits-1:0] AccMin = {1'b1, {(AccumBits-1){1'b0}}};
  localparam logic [32:0] TwoPiMul = 33'd6746518852;

  logic signed [23:0] px_q, py_q, pz_q;
  logic signed [19:0] ff_q;
  logic last_q;
  logic [1:0] sel_q;
  logic signed [PhaseBits-1:0] ph_q;
  logic signed [41:0] prod;
  logic signed [17:0] qsel;
  logic signed [23:0] psel;
  // reduction: reciprocal estimate of the 2pi quotient, then one compare and subtract
  logic [RedBits-1:0] rk_q;
  logic [14:0] qe_q;
  logic neg_q;
  logic signed [CBits-1:0] x_q, y_q, z_q;
  logic [StepBits-1:0] it_q;
  logic signed [CBits+20-1:0] tr_q, ti_q;
  logic signed [AccumBits-1:0] racc_q, iacc_q;

  always_comb begin
    unique case (sel_q)
      2'd0: begin qsel = qx_i; psel = px_q; end
      2'd1: begin qsel = qy_i; psel = py_q; end
      default: begin qsel = qz_i; psel = pz_q; end
    endcase
  end
  assign prod = qsel * psel;

  logic signed [PhaseBits-1:0] ph_sum;
  assign ph_sum = ph_q + (PhaseBits'(prod) <<< 4);

  // quotient estimate, at most one short of the true quotient
  logic [62:0] qe_prod;
  assign qe_prod = ph_q[PhaseBits-2:16] * RecipTwoPi;
  logic [PhaseBits-1:0] qe_mult;
  assign qe_mult = qe_q * TwoPiMul;

  logic signed [PhaseBits-1:0] r_wrap;
  assign r_wrap = (ph_q >= PiQ30) ? ph_q - TwoPiQ30 : ph_q;

  logic signed [CBits-1:0] dx, dy, at;
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = atan_q30(5'(it_q));

  logic signed [CBits+20-1:0] fc, fs, fcr, fsr;
  assign fc = ff_q * x_q;
  assign fs = ff_q * y_q;
  assign fcr = (tr_q + 54'sd524288) >>> 20;
  assign fsr = (ti_q + 54'sd524288) >>> 20;

  function automatic logic signed [AccumBits-1:0] sat_add(
    input logic signed [AccumBits-1:0] a, input logic signed [CBits+20-1:0] t);
    logic signed [AccumBits+CBits+20:0] s;
    s = (AccumBits+CBits+21)'(a) + (AccumBits+CBits+21)'(t);
    if (s > (AccumBits+CBits+21)'(AccMax)) return AccMax;
    if (s < (AccumBits+CBits+21)'(AccMin)) return AccMin;
    return s[AccumBits-1:0];
  endfunction

  assign sts_o.red_done = (rk_q == '0);
  assign sts_o.cordic_done = (it_q == StepBits'(CordicSteps-1));
  assign sts_o.last = last_q;
  assign real_o = racc_q;
  assign imag_neg_o = (iacc_q == AccMin) ? AccMax : -iacc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= px_i; py_q <= py_i; pz_q <= pz_i; ff_q <= ff_i; last_q <= last_i;
      sel_q <= '0; ph_q <= '0;
    end
    if (cmd_i.mul_step) begin
      sel_q <= sel_q + 2'd1;
      rk_q <= RedBits'(2);
      // non-negative remainder: bias a negative phase by 2pi*2^13
      if (sel_q == 2'd2 && ph_sum < 0) ph_q <= ph_sum + (TwoPiQ30 <<< 13);
      else ph_q <= ph_sum;
    end
    if (cmd_i.red_step) begin
      unique case (rk_q)
        2'd2: qe_q <= qe_prod[62:48];
        2'd1: ph_q <= ph_q - $signed(qe_mult);
        default: begin
          if (ph_q >= TwoPiQ30) ph_q <= ph_q - TwoPiQ30;
        end
      endcase
      if (rk_q != '0) rk_q <= rk_q - 1'b1;
    end
    if (cmd_i.cordic_init) begin
      x_q <= GainQ30; y_q <= '0; it_q <= '0;
      if (r_wrap > HalfPiQ30) begin
        z_q <= CBits'(r_wrap - PiQ30); neg_q <= 1'b1;
      end else if (r_wrap < -HalfPiQ30) begin
        z_q <= CBits'(r_wrap + PiQ30); neg_q <= 1'b1;
      end else begin
        z_q <= CBits'(r_wrap); neg_q <= 1'b0;
      end
    end
    if (cmd_i.cordic_step) begin
      if (!z_q[CBits-1]) begin
        x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
      end
      it_q <= it_q + 1'b1;
    end
    if (cmd_i.term) begin
      tr_q <= neg_q ? -fc : fc;
      ti_q <= neg_q ? -fs : fs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      racc_q <= '0;
      iacc_q <= '0;
    end else if (cmd_i.out_load) begin
      racc_q <= '0;
      iacc_q <= '0;
    end else if (cmd_i.acc) begin
      racc_q <= sat_add(racc_q, fcr);
      iacc_q <= sat_add(iacc_q, fsr);
    end
  end
endmodule

// ===== hw/rtl/scattering_amplitude_accumulator.sv =====
// per atom: transfer, multiply, reduction, fix, cordic, term and accumulate, in that order
// one atom at a time: a new atom is accepted only in idle, once the previous one is accumulated
// a last atom waits in accumulate while the previous result is not yet transferred
// last atom: result registered in the cycle after accumulation, held until transferred
// reset: asynchronous active low, clears q registers, accumulators and control
module scattering_amplitude_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  saa_in_if.sink      in_if,
  saa_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i
);
  import saa_pkg::*;

  localparam logic [1:0] RegQx = 2'd0;
  localparam logic [1:0] RegQy = 2'd1;
  localparam logic [1:0] RegQz = 2'd2;

  logic signed [17:0] qx_q, qy_q, qz_q;
  saa_cmd_t cmd;
  saa_sts_t sts;
  logic signed [AccumBits-1:0] real_w, imag_w;
  logic out_valid_q;
  logic signed [OutBits-1:0] out_r_q, out_i_q;

  // scattering vector registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0; qy_q <= '0; qz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegQx: qx_q <= cfg_data_i;
        RegQy: qy_q <= cfg_data_i;
        RegQz: qz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  saa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_busy_i(out_valid_q), .sts_i(sts), .cmd_o(cmd)
  );

  saa_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .qx_i(qx_q), .qy_i(qy_q), .qz_i(qz_q),
    .px_i(in_if.pos_x), .py_i(in_if.pos_y), .pz_i(in_if.pos_z),
    .ff_i(in_if.form_factor), .last_i(in_if.last_atom),
    .real_o(real_w), .imag_neg_o(imag_w)
  );

  // output register, loaded from the finished sums before they clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.out_load) out_valid_q <= 1'b1;
    else if (out_if.ready) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_r_q <= real_w[OutBits-1:0];
      out_i_q <= imag_w[OutBits-1:0];
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.amp_real = out_r_q;
  assign out_if.amp_imag = out_i_q;

  a_no_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.out_load && out_valid_q)) else $error("result overwritten");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul_step, cmd.red_step, cmd.cordic_step, cmd.acc}))
    else $error("conflicting commands");
endmodule

// ===== tb/scattering_amplitude_accumulator_tb.sv =====
`timescale 1ns / 1ps

module scattering_amplitude_accumulator_tb;
  import saa_pkg::*;

  // register indexes of the configuration port
  localparam logic [1:0] RegQx = 2'd0;
  localparam logic [1:0] RegQy = 2'd1;
  localparam logic [1:0] RegQz = 2'd2;
  localparam logic [1:0] RegUnused = 2'd3;

  // fixed-point constants of the phase reduction and the rotation
  localparam longint TwoPi = 64'sd6746518852;
  localparam longint Pi = 64'sd3373259426;
  localparam longint HalfPi = 64'sd1686629713;
  localparam longint Gain = 64'sd652032874;
  localparam longint AccMax = (64'sd1 <<< (AccumBits - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [19:0] form_factor;
    logic last_atom;
  } atom_t;

  typedef struct packed {
    logic signed [47:0] amp_real;
    logic signed [47:0] amp_imag;
  } amp_t;

  // directed row: an atom, and the amplitude typed in where it is obvious
  typedef struct packed {
    atom_t atom;
    logic typed;
    amp_t amp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [17:0] cfg_data_i;

  saa_in_if in_if ();
  saa_out_if out_if ();

  scattering_amplitude_accumulator uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if.sink),
    .out_if    (out_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // local copy of the scattering vector and the two running sums
  logic signed [17:0] q_x, q_y, q_z;
  longint real_sum, imag_sum;
  amp_t amp_q[$];
  bit failed;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cosine and sine of the phase, both in Q.30
  function automatic void sin_cos(input longint phase, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = phase % TwoPi;
    if (r < 0) r += TwoPi;
    if (r >= Pi) r -= TwoPi;
    flip = 1'b0;
    if (r > HalfPi) begin
      r -= Pi;
      flip = 1'b1;
    end else if (r < -HalfPi) begin
      r += Pi;
      flip = 1'b1;
    end
    x = Gain;
    y = 0;
    z = r;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_q30(i[4:0]));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_q30(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint sat_sum(input longint a, input longint t);
    longint v;
    v = a + t;
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  // folds one atom into the sums; returns 1 with the amplitude on the last atom
  function automatic bit fold_atom(input atom_t a, output amp_t amp);
    longint phase, c, s, f, im;
    phase = (longint'(q_x) * longint'(a.pos_x) + longint'(q_y) * longint'(a.pos_y)
             + longint'(q_z) * longint'(a.pos_z)) * 16;
    sin_cos(phase, c, s);
    f = longint'(a.form_factor);
    real_sum = sat_sum(real_sum, (f * c + (64'sd1 <<< 19)) >>> 20);
    imag_sum = sat_sum(imag_sum, (f * s + (64'sd1 <<< 19)) >>> 20);
    amp = '0;
    if (!a.last_atom) return 1'b0;
    im = (imag_sum == AccMin) ? AccMax : -imag_sum;
    amp.amp_real = real_sum[47:0];
    amp.amp_imag = im[47:0];
    real_sum = 0;
    imag_sum = 0;
    return 1'b1;
  endfunction

  // write enable stays high for back-to-back writes, the caller drops it
  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegQx: q_x = val;
      RegQy: q_y = val;
      RegQz: q_z = val;
      default: ;
    endcase
  endtask

  // waits for every pending amplitude, then lets a non-last atom drain
  task automatic wait_idle();
    while (amp_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_vector(input logic [17:0] qx, input logic [17:0] qy,
                            input logic [17:0] qz);
    in_if.valid <= 1'b0;
    wait_idle();
    @(posedge clk_i);
    write_reg(RegQx, qx);
    write_reg(RegQy, qy);
    write_reg(RegQz, qz);
    // index with no register behind it, must leave the vector alone
    write_reg(RegUnused, 18'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // offers one atom, with an occasional idle burst in front of it
  task automatic send_atom(input atom_t a, input bit typed, input amp_t typed_amp);
    amp_t amp;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.pos_x <= a.pos_x;
    in_if.pos_y <= a.pos_y;
    in_if.pos_z <= a.pos_z;
    in_if.form_factor <= a.form_factor;
    in_if.last_atom <= a.last_atom;
    do @(posedge clk_i); while (!in_if.ready);
    if (fold_atom(a, amp)) amp_q.push_back(typed ? typed_amp : amp);
  endtask

  function automatic logic [23:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($urandom_range(0, 8191)) - 24'd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_ff();
    case ($urandom_range(0, 7))
      0: return 20'h80000;
      1: return 20'h7ffff;
      2: return 20'd0;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [17:0] pick_q();
    case ($urandom_range(0, 5))
      0: return 18'h20000;
      1: return 18'h1ffff;
      2: return 18'($urandom_range(0, 1023)) - 18'd512;
      default: return 18'($urandom);
    endcase
  endfunction

  // result side: check each transfer, stall in random bursts
  initial begin
    int stall;
    out_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (amp_q.size() == 0) begin
          $error("amplitude with none expected: real %0d imag %0d",
                 out_if.amp_real, out_if.amp_imag);
          failed = 1'b1;
        end else begin
          amp_t want;
          want = amp_q.pop_front();
          if (out_if.amp_real !== want.amp_real) begin
            $error("amp_real: expected %0d, got %0d", want.amp_real, out_if.amp_real);
            failed = 1'b1;
          end
          if (out_if.amp_imag !== want.amp_imag) begin
            $error("amp_imag: expected %0d, got %0d", want.amp_imag, out_if.amp_imag);
            failed = 1'b1;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // hard limit on the run
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    row_t rows[$];
    atom_t a;
    amp_t nil;
    int total;
    int set_len;
    failed = 1'b0;
    quiet = 1'b0;
    real_sum = 0;
    imag_sum = 0;
    q_x = '0;
    q_y = '0;
    q_z = '0;
    nil = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegQx;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.form_factor = '0;
    in_if.last_atom = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: a zero form factor gives a zero amplitude whatever the phase
    rows = '{
      '{'{24'h000000, 24'h000000, 24'h000000, 20'h00000, 1'b1}, 1'b1, '0},
      '{'{24'h7fffff, 24'h800000, 24'h000001, 20'h00000, 1'b1}, 1'b1, '0},
      '{'{24'h000000, 24'h000000, 24'h000000, 20'h7ffff, 1'b1}, 1'b0, '0},
      '{'{24'h000000, 24'h000000, 24'h000000, 20'h80000, 1'b1}, 1'b0, '0},
      '{'{24'h7fffff, 24'h7fffff, 24'h7fffff, 20'h7ffff, 1'b0}, 1'b0, '0},
      '{'{24'h800000, 24'h800000, 24'h800000, 20'h80000, 1'b0}, 1'b0, '0},
      '{'{24'h7fffff, 24'h800000, 24'h7fffff, 20'h7ffff, 1'b1}, 1'b0, '0},
      '{'{24'h001000, 24'hfff000, 24'h000800, 20'h00400, 1'b0}, 1'b0, '0},
      '{'{24'hffffff, 24'h000001, 24'h000000, 20'hfffff, 1'b1}, 1'b0, '0},
      '{'{24'h000800, 24'h000000, 24'h000000, 20'h00400, 1'b1}, 1'b0, '0},
      '{'{24'h7fffff, 24'h7fffff, 24'h7fffff, 20'h80000, 1'b1}, 1'b0, '0},
      '{'{24'h800000, 24'h7fffff, 24'h800000, 20'h7ffff, 1'b1}, 1'b0, '0}
    };
    // once with the reset vector, then with extreme and mixed vectors
    for (int pass = 0; pass < 3; pass++) begin
      if (pass == 1) set_vector(18'h1ffff, 18'h20000, 18'h1ffff);
      if (pass == 2) set_vector(18'h20000, 18'h20000, 18'h20000);
      foreach (rows[i]) send_atom(rows[i].atom, rows[i].typed, rows[i].amp);
    end

    // random sets of atoms, mostly well formed, with a new vector now and then
    total = 0;
    while (total < 1800) begin
      if ($urandom_range(0, 14) == 0) set_vector(pick_q(), pick_q(), pick_q());
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++) begin
        a.pos_x = pick_pos();
        a.pos_y = pick_pos();
        a.pos_z = pick_pos();
        a.form_factor = pick_ff();
        // a stray last flag now and then breaks a set early
        a.last_atom = (k == set_len - 1) || ($urandom_range(0, 19) == 0);
        quiet = (total > 1600);
        send_atom(a, 1'b0, nil);
        total++;
      end
    end
    in_if.valid <= 1'b0;

    while (amp_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/saa_pkg.sv
hw/rtl/saa_if.sv
hw/rtl/saa_ctrl.sv
hw/rtl/saa_dp.sv
hw/rtl/scattering_amplitude_accumulator.sv
tb/scattering_amplitude_accumulator_tb.sv
